### rtl/hash_min_cost_set_macros.svh
// Assertion macros shared by the hash set RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef HASH_MIN_COST_SET_MACROS_SVH
`define HASH_MIN_COST_SET_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HMCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HMCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hmcs_pkg.sv
// Types and constants of the minimum-cost hash set.
// Depends on nothing; used by hmcs_mix and hash_min_cost_set.
package hmcs_pkg;

    localparam int KEY_BITS       = 30;
    localparam int COST_BITS      = 8;
    localparam int SLOT_OUT_BITS  = 12;
    localparam int COUNT_OUT_BITS = 12;

    localparam logic [63:0] MIX_ADD  = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_MUL1 = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL2 = 64'h94d0_49bb_1331_11eb;
    localparam int MIX_SHIFT0 = 30;
    localparam int MIX_SHIFT1 = 27;
    localparam int MIX_SHIFT2 = 31;

    typedef enum logic [2:0] {
        STAT_NEW        = 3'd0,
        STAT_LOWERED    = 3'd1,
        STAT_KEPT       = 3'd2,
        STAT_ZERO_KEY   = 3'd3,
        STAT_FULL       = 3'd4,
        STAT_SLOT_EMPTY = 3'd5,
        STAT_SLOT_USED  = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_PROBE
    } t_state;

    typedef struct packed {
        logic                     mode;
        logic [KEY_BITS-1:0]      key;
        logic [COST_BITS-1:0]     cost;
        logic [SLOT_OUT_BITS-1:0] slot_index;
    } t_item;

    typedef struct packed {
        t_status                   status;
        logic [SLOT_OUT_BITS-1:0]  slot;
        logic [KEY_BITS-1:0]       stored_key;
        logic [COST_BITS-1:0]      stored_cost;
        logic [COUNT_OUT_BITS-1:0] entry_count;
    } t_result;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [COST_BITS-1:0] cost;
    } t_entry;

endpackage

### rtl/hmcs_mix.sv
// Multi-cycle splitmix64 finaliser built around one 32 by 32 bit multiplier.
// Depends on hmcs_pkg for the mixing constants and the key width.
module hmcs_mix (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hmcs_pkg::KEY_BITS-1:0] i_key,
    output logic                         o_done,
    output logic [63:0]                  o_hash
);
    import hmcs_pkg::*;

    logic        r_run;
    logic        r_done;
    logic [2:0]  r_cnt;
    logic [63:0] r_x;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] r_hash;

    logic [63:0] seed;
    logic [63:0] mul_k;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;
    logic [63:0] sum;

    assign seed  = 64'(i_key) + MIX_ADD;
    assign mul_k = r_cnt[2] ? MIX_MUL2 : MIX_MUL1;
    assign op_a  = (r_cnt[1:0] == 2'd2) ? r_x[63:32] : r_x[31:0];
    assign op_b  = (r_cnt[1:0] == 2'd1) ? mul_k[63:32] : mul_k[31:0];
    assign prod  = 64'(op_a) * 64'(op_b);
    assign sum   = r_acc + {r_prod[31:0], 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= seed ^ (seed >> MIX_SHIFT0);
        end else if (r_run) begin
            r_prod <= prod;
            case (r_cnt[1:0])
                2'd1: r_acc <= r_prod;
                2'd2: r_acc <= sum;
                2'd3: begin
                    if (r_cnt[2]) begin
                        r_hash <= sum ^ (sum >> MIX_SHIFT2);
                    end else begin
                        r_x <= sum ^ (sum >> MIX_SHIFT1);
                    end
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_hash = r_hash;

endmodule

### rtl/hash_min_cost_set.sv
// Minimum-cost hash set: top level with the slot memory and the probe controller.
// Depends on hmcs_pkg, hmcs_mix and hash_min_cost_set_macros.svh.
//
// Usage: a transaction is offered on i_item with start and is taken at a
// rising edge where start is high and busy is low. Mode 0 inserts a key or
// lowers its cost, mode 1 reads one slot so the table can be walked.
// Exactly one result per transaction appears on o_result for one cycle,
// marked by o_strobe; the receiver cannot stall, so it must take it then.
// Path to the strobe: a slot read passes ST_READ, a zero key is answered
// from ST_IDLE, and an insert passes ST_HASH, then ST_PROBE once per slot;
// the splitmix64 hash runs through one shared multiplier and linear
// probing reads the slot memory once per cycle. busy falls in the strobe
// cycle, so no new transaction is taken before the last one is answered.
// At reset the table is cleared one slot per cycle, busy high throughout.
// The occupancy is held at three quarters of SLOT_COUNT; a new key beyond
// that is refused as full.
`include "hash_min_cost_set_macros.svh"

module hash_min_cost_set #(
    parameter int SLOT_COUNT = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  hmcs_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_strobe,
    output hmcs_pkg::t_result o_result
);
    import hmcs_pkg::*;

    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int LOAD_LIMIT = SLOT_COUNT - SLOT_COUNT / 4;
    localparam int CNT_W      = $clog2(LOAD_LIMIT + 1);
    localparam int SW         = (IDX_W > SLOT_OUT_BITS) ? IDX_W : SLOT_OUT_BITS;
    localparam int CW         = (CNT_W > COUNT_OUT_BITS) ? CNT_W : COUNT_OUT_BITS;

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_clr_idx, n_clr_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;
    t_entry             r_rdata;
    t_entry             r_mem [0:SLOT_COUNT-1];

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic               mix_start;
    logic               mix_done;
    logic [63:0]        mix_hash;

    logic [SW-1:0]      si_ext;
    logic [SW-1:0]      slot_ext;
    logic [CW-1:0]      cnt_now_ext;
    logic [CW-1:0]      cnt_inc_ext;
    logic [IDX_W-1:0]   rd_idx;
    logic               slot_empty;
    logic               slot_match;
    logic               at_limit;
    logic               lower;

    assign si_ext      = SW'(i_item.slot_index);
    assign rd_idx      = si_ext[IDX_W-1:0];
    assign slot_ext    = SW'(r_idx);
    assign cnt_now_ext = CW'(r_count);
    assign cnt_inc_ext = CW'(r_count) + CW'(1);
    assign slot_empty  = (r_rdata.key == '0);
    assign slot_match  = (r_rdata.key == r_item.key);
    assign at_limit    = (r_count >= CNT_W'(LOAD_LIMIT));
    assign lower       = (r_item.cost < r_rdata.cost);

    hmcs_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mix_start),
        .i_key   (i_item.key),
        .o_done  (mix_done),
        .o_hash  (mix_hash)
    );

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_idx       = r_idx;
        n_clr_idx   = r_clr_idx;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (&r_clr_idx) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    if (i_item.mode) begin
                        n_idx   = rd_idx;
                        n_state = ST_READ;
                    end else if (i_item.key == '0) begin
                        n_out_valid       = 1'b1;
                        n_out.status      = STAT_ZERO_KEY;
                        n_out.slot        = '0;
                        n_out.stored_key  = '0;
                        n_out.stored_cost = '0;
                        n_out.entry_count = cnt_now_ext[COUNT_OUT_BITS-1:0];
                    end else begin
                        n_state = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                if (mix_done) begin
                    n_idx   = mix_hash[IDX_W-1:0];
                    n_state = ST_PROBE;
                end
            end
            ST_READ: begin
                n_state           = ST_IDLE;
                n_out_valid       = 1'b1;
                n_out.status      = slot_empty ? STAT_SLOT_EMPTY : STAT_SLOT_USED;
                n_out.slot        = slot_ext[SLOT_OUT_BITS-1:0];
                n_out.stored_key  = r_rdata.key;
                n_out.stored_cost = slot_empty ? '0 : r_rdata.cost;
                n_out.entry_count = cnt_now_ext[COUNT_OUT_BITS-1:0];
            end
            ST_PROBE: begin
                n_out.slot = slot_ext[SLOT_OUT_BITS-1:0];
                if (slot_empty) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    if (at_limit) begin
                        n_out.status      = STAT_FULL;
                        n_out.stored_key  = '0;
                        n_out.stored_cost = '0;
                        n_out.entry_count = cnt_now_ext[COUNT_OUT_BITS-1:0];
                    end else begin
                        n_count           = r_count + 1'b1;
                        n_out.status      = STAT_NEW;
                        n_out.stored_key  = r_item.key;
                        n_out.stored_cost = r_item.cost;
                        n_out.entry_count = cnt_inc_ext[COUNT_OUT_BITS-1:0];
                    end
                end else if (slot_match) begin
                    n_state           = ST_IDLE;
                    n_out_valid       = 1'b1;
                    n_out.stored_key  = r_item.key;
                    n_out.entry_count = cnt_now_ext[COUNT_OUT_BITS-1:0];
                    if (lower) begin
                        n_out.status      = STAT_LOWERED;
                        n_out.stored_cost = r_item.cost;
                    end else begin
                        n_out.status      = STAT_KEPT;
                        n_out.stored_cost = r_rdata.cost;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        mem_raddr = r_idx;
        mix_start = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
            end
            ST_IDLE: begin
                mem_raddr = rd_idx;
                mix_start = start && !i_item.mode && (i_item.key != '0);
            end
            ST_HASH: begin
                mem_raddr = mix_hash[IDX_W-1:0];
            end
            ST_READ: begin
                mem_raddr = r_idx;
            end
            ST_PROBE: begin
                mem_wdata.key  = r_item.key;
                mem_wdata.cost = r_item.cost;
                mem_raddr      = r_idx + 1'b1;
                if (slot_empty) begin
                    mem_we = !at_limit;
                end else if (slot_match) begin
                    mem_we = lower;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

    assign busy     = (r_state != ST_IDLE) || !i_rst_n;
    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    `HMCS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(LOAD_LIMIT), "Occupancy exceeds the load limit.")
    `HMCS_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_strobe, "Accepted transaction neither in progress nor answered.")
    `HMCS_ASSERT_SAME(a_write_states, i_clk, i_rst_n, mem_we, r_state == ST_CLEAR || r_state == ST_PROBE, "Slot memory written outside clearing or probing.")
    `HMCS_ASSERT_SAME(a_new_counts, i_clk, i_rst_n, o_strobe && o_result.status == STAT_NEW, r_count == $past(r_count) + CNT_W'(1), "New entry did not raise the occupancy by one.")

endmodule

### verif/testbench.sv
// Self-checking testbench for hash_min_cost_set: drives inserts, zero keys and slot reads,
// predicts each result from its own copy of the table and checks every strobed result.
// Depends on hmcs_pkg and the hash_min_cost_set RTL.
module testbench;
    import hmcs_pkg::*;

    localparam int SLOTS        = 4096;
    localparam int LOAD_LIMIT   = SLOTS - SLOTS / 4;
    localparam int RANDOM_ITEMS = 500;
    localparam int WALK_SLOTS   = 64;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_LIMIT = 50;
    localparam int RESULT_W     = $bits(t_result);
    localparam logic [KEY_BITS-1:0] KEY_MAX = '1;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    logic [KEY_BITS-1:0]      model_keys [SLOTS];
    logic [COST_BITS-1:0]     model_costs[SLOTS];
    int                       model_occupancy = 0;
    t_result                  expected_results[$];
    logic [KEY_BITS-1:0]      landed_keys[$];
    logic [SLOT_OUT_BITS-1:0] landed_slots[$];
    int                       mismatch_count = 0;
    int                       quiet_cycles = 0;
    bit                       gaps_enabled = 1'b1;

    hash_min_cost_set dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] mix_key(input logic [63:0] v);
        v = v + MIX_ADD;
        v = (v ^ (v >> MIX_SHIFT0)) * MIX_MUL1;
        v = (v ^ (v >> MIX_SHIFT1)) * MIX_MUL2;
        return v ^ (v >> MIX_SHIFT2);
    endfunction

    function automatic t_result hash_set_apply(input t_item item);
        t_result                  r;
        logic [63:0]              mixed;
        logic [SLOT_OUT_BITS-1:0] idx;
        int                       steps;
        r = '0;
        if (item.mode) begin
            idx    = item.slot_index;
            r.slot = idx;
            if (model_keys[idx] == '0) begin
                r.status = STAT_SLOT_EMPTY;
            end else begin
                r.status      = STAT_SLOT_USED;
                r.stored_key  = model_keys[idx];
                r.stored_cost = model_costs[idx];
            end
        end else if (item.key == '0) begin
            r.status = STAT_ZERO_KEY;
        end else begin
            mixed = mix_key(64'(item.key));
            idx   = mixed[SLOT_OUT_BITS-1:0];
            steps = 0;
            while (steps < SLOTS && model_keys[idx] != '0 && model_keys[idx] != item.key) begin
                idx++;
                steps++;
            end
            r.slot = idx;
            if (model_keys[idx] == '0) begin
                if (model_occupancy + 1 > LOAD_LIMIT) begin
                    r.status = STAT_FULL;
                end else begin
                    model_keys[idx]  = item.key;
                    model_costs[idx] = item.cost;
                    model_occupancy++;
                    r.status      = STAT_NEW;
                    r.stored_key  = item.key;
                    r.stored_cost = item.cost;
                end
            end else if (model_keys[idx] != item.key) begin
                r.status = STAT_FULL;
            end else if (item.cost < model_costs[idx]) begin
                model_costs[idx] = item.cost;
                r.status      = STAT_LOWERED;
                r.stored_key  = item.key;
                r.stored_cost = item.cost;
            end else begin
                r.status      = STAT_KEPT;
                r.stored_key  = item.key;
                r.stored_cost = model_costs[idx];
            end
        end
        r.entry_count = COUNT_OUT_BITS'(model_occupancy);
        return r;
    endfunction

    function automatic t_item insert_item(input logic [KEY_BITS-1:0] key,
                                          input logic [COST_BITS-1:0] cost);
        t_item item;
        item.mode       = 1'b0;
        item.key        = key;
        item.cost       = cost;
        item.slot_index = SLOT_OUT_BITS'($urandom);
        return item;
    endfunction

    function automatic t_item read_item(input logic [SLOT_OUT_BITS-1:0] slot);
        t_item item;
        item.mode       = 1'b1;
        item.key        = KEY_BITS'($urandom);
        item.cost       = COST_BITS'($urandom);
        item.slot_index = slot;
        return item;
    endfunction

    function automatic logic [KEY_BITS-1:0] fresh_key();
        return KEY_BITS'($urandom_range(32'(KEY_MAX), 1));
    endfunction

    task automatic report_mismatch(input string field,
                                   input logic [RESULT_W-1:0] got,
                                   input logic [RESULT_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
        end
    endtask

    task automatic pause_sender();
        int pick;
        int gap;
        gap  = 0;
        pick = $urandom_range(0, 19);
        if (gaps_enabled) begin
            if (pick == 0) begin
                gap = $urandom_range(30, 120);
            end else if (pick < 4) begin
                gap = $urandom_range(4, 15);
            end else if (pick < 11) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_item(input t_item item);
        t_result predicted;
        start  <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = hash_set_apply(item);
        expected_results.insert(expected_results.size(), predicted);
        if (predicted.status == STAT_NEW) begin
            landed_keys.insert(landed_keys.size(), item.key);
            landed_slots.insert(landed_slots.size(), predicted.slot);
        end
        pause_sender();
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic test_directed_cases();
        logic [KEY_BITS-1:0] home_keys[$];
        logic [KEY_BITS-1:0] candidate;
        logic [63:0]         mixed;
        candidate = KEY_BITS'(2);
        while (home_keys.size() < 3) begin
            candidate++;
            mixed = mix_key(64'(candidate));
            if (&mixed[SLOT_OUT_BITS-1:0]) begin
                home_keys.insert(home_keys.size(), candidate);
            end
        end
        gaps_enabled = 1'b1;
        send_item(read_item('0));
        send_item(read_item(SLOT_OUT_BITS'(SLOTS - 1)));
        send_item(insert_item('0, 8'd255));
        send_item(insert_item(KEY_BITS'(1), 8'd255));
        send_item(insert_item(KEY_BITS'(1), 8'd255));
        send_item(insert_item(KEY_BITS'(1), 8'd0));
        send_item(insert_item(KEY_BITS'(1), 8'd255));
        send_item(insert_item(KEY_MAX, 8'd0));
        send_item(insert_item(KEY_MAX, 8'd0));
        foreach (home_keys[i]) begin
            send_item(insert_item(home_keys[i], COST_BITS'(10 * (i + 1))));
        end
        send_item(insert_item(home_keys[2], 8'd5));
        send_item(insert_item(home_keys[1], 8'd200));
        send_item(read_item(SLOT_OUT_BITS'(SLOTS - 1)));
        send_item(read_item(SLOT_OUT_BITS'(0)));
        send_item(read_item(SLOT_OUT_BITS'(1)));
        send_item(read_item(landed_slots[0]));
        drain_results();
    endtask

    task automatic test_random_traffic();
        int pick;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                gaps_enabled = ($urandom_range(0, 3) != 0);
            end
            if (n % 100 == 50 && (n == 350 || $urandom_range(0, 2) == 0)) begin
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 40 || landed_keys.size() == 0) begin
                send_item(insert_item(fresh_key(), COST_BITS'($urandom)));
            end else if (pick < 65) begin
                send_item(insert_item(landed_keys[$urandom_range(0, landed_keys.size() - 1)],
                                      COST_BITS'($urandom)));
            end else if (pick < 70) begin
                send_item(insert_item('0, COST_BITS'($urandom)));
            end else if (pick < 85) begin
                send_item(read_item(landed_slots[$urandom_range(0, landed_slots.size() - 1)]));
            end else begin
                send_item(read_item(SLOT_OUT_BITS'($urandom)));
            end
        end
        gaps_enabled = 1'b1;
    endtask

    task automatic test_table_walk();
        logic [SLOT_OUT_BITS-1:0] walk_base;
        walk_base = SLOT_OUT_BITS'(SLOTS - WALK_SLOTS / 2);
        for (int s = 0; s < WALK_SLOTS; s++) begin
            send_item(read_item(walk_base + SLOT_OUT_BITS'(s)));
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result due;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", o_result, '0);
            end else begin
                due = expected_results.pop_front();
                if (o_result.status !== due.status) begin
                    report_mismatch("status", RESULT_W'(o_result.status),
                                    RESULT_W'(due.status));
                end
                if (o_result.slot !== due.slot) begin
                    report_mismatch("slot", RESULT_W'(o_result.slot), RESULT_W'(due.slot));
                end
                if (o_result.stored_key !== due.stored_key) begin
                    report_mismatch("stored_key", RESULT_W'(o_result.stored_key),
                                    RESULT_W'(due.stored_key));
                end
                if (o_result.stored_cost !== due.stored_cost) begin
                    report_mismatch("stored_cost", RESULT_W'(o_result.stored_cost),
                                    RESULT_W'(due.stored_cost));
                end
                if (o_result.entry_count !== due.entry_count) begin
                    report_mismatch("entry_count", RESULT_W'(o_result.entry_count),
                                    RESULT_W'(due.entry_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL hash_min_cost_set");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            model_keys[s]  = '0;
            model_costs[s] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic();
        test_table_walk();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS hash_min_cost_set");
        end else begin
            $display("FAIL hash_min_cost_set");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/hmcs_pkg.sv
rtl/hmcs_mix.sv
rtl/hash_min_cost_set.sv
verif/testbench.sv
